// ----- src/acc_cpu_pkg.sv -----
// shared opcodes, service codes and status codes of the accumulator cpu execute block
package acc_cpu_pkg;

  // service operation of an input beat
  localparam logic [1:0] OP_EXEC   = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_SETPC  = 2'd2;
  localparam logic [1:0] OP_SETACC = 2'd3;

  // instruction opcodes, the rest are illegal
  localparam logic [3:0] OPC_CARGI = 4'd0;
  localparam logic [3:0] OPC_CARGM = 4'd1;
  localparam logic [3:0] OPC_CARGX = 4'd2;
  localparam logic [3:0] OPC_ARMM  = 4'd3;
  localparam logic [3:0] OPC_ARMX  = 4'd4;
  localparam logic [3:0] OPC_SOMA  = 4'd5;
  localparam logic [3:0] OPC_NEG   = 4'd6;
  localparam logic [3:0] OPC_DESVZ = 4'd7;
  localparam logic [3:0] OPC_PARA  = 4'd8;
  localparam logic [3:0] OPC_LE    = 4'd9;
  localparam logic [3:0] OPC_GRAVA = 4'd10;

  // result status
  localparam logic [2:0] ST_NORMAL    = 3'd0;
  localparam logic [2:0] ST_STOP      = 3'd1;
  localparam logic [2:0] ST_READ      = 3'd2;
  localparam logic [2:0] ST_WRITE     = 3'd3;
  localparam logic [2:0] ST_ILLEGAL   = 3'd4;
  localparam logic [2:0] ST_VIOLATION = 3'd5;

endpackage

// ----- src/acc_cpu_ifs.sv -----
// valid/ready channel interfaces for the input and result beats
interface acc_cpu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         opcode;
  logic signed [31:0] operand;
  logic [7:0]         load_address;
  logic signed [31:0] load_value;

  modport source (output valid, output op, output opcode, output operand,
                  output load_address, output load_value, input ready);
  modport sink   (input valid, input op, input opcode, input operand,
                  input load_address, input load_value, output ready);
endinterface

interface acc_cpu_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_pc;
  logic signed [31:0] acc_value;
  logic [2:0]         status;
  logic [7:0]         highest_address;

  modport source (output valid, output next_pc, output acc_value, output status,
                  output highest_address, input ready);
  modport sink   (input valid, input next_pc, input acc_value, input status,
                   input highest_address, output ready);
endinterface

// ----- src/acc_cpu_dmem.sv -----
// data memory: one write port, one registered read port with same-edge write forwarding
module acc_cpu_dmem #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] q_r;
  logic        fwd_hit_r;
  logic [31:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write to the same entry at the read edge wins over the old contents
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : q_r;

endmodule

// ----- src/accumulator_cpu_execute_top.sv -----
// top level of the accumulator cpu execute block
//
// Executes one accumulator-machine instruction, or one service write, per input beat and
// returns one result beat per input beat: the pc and accumulator after it, a status code and
// the highest data address stored so far. All state except pc, accumulator and the highest
// address lives in a DATA_DEPTH x 32 data memory with a single registered read port. Beats
// flow back to back at one per cycle while the result register is free or being taken;
// the indirect load (CARGX) holds the execute stage for a dependent read of M[M[n]] on
// the same port. Each beat is registered in the execute stage and then in the output
// register, which lets the next beat enter while a result waits to be taken. After reset
// the block sweeps the memory to zero, one word a cycle, holding in ready low until the
// sweep ends. Out-of-range data addresses and a pc at or beyond PROG_DEPTH give a memory
// violation status and leave accumulator, memory and highest address unchanged.
module accumulator_cpu_execute_top #(
  parameter int DATA_DEPTH = 256,
  parameter int PROG_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  acc_cpu_in_if.sink   in_chan,
  acc_cpu_out_if.source out_chan
);

  import acc_cpu_pkg::*;

  localparam int AW = $clog2(DATA_DEPTH);

  // architectural state outside the memory
  logic [31:0]   acc_r, acc_nxt;
  logic [15:0]   pc_r, pc_nxt;
  logic [AW-1:0] hi_r, hi_nxt;

  // execute stage
  logic          e_vld_r;
  logic          e_phase_r;      // set while a CARGX waits for its second read
  logic [1:0]    e_op_r;
  logic [3:0]    e_opcode_r;
  logic [31:0]   e_operand_r;
  logic [7:0]    e_la_r;
  logic [31:0]   e_lv_r;

  // result register
  logic          o_vld_r;
  logic [15:0]   o_pc_r;
  logic [31:0]   o_acc_r;
  logic [2:0]    o_st_r;
  logic [AW-1:0] o_hi_r;

  // clearing sweep after reset
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  // memory ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rdata;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // execute decode
  logic          pc_ok, n_ok, d_ok, la_ok;
  logic [2:0]    st;
  logic          wr_req;
  logic [AW-1:0] wr_a;
  logic [31:0]   wr_d;
  logic          need2;
  logic          slot_free, fire, step2, in_fire;

  acc_cpu_dmem #(.DEPTH(DATA_DEPTH)) u_dmem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // range checks
  assign pc_ok = {1'b0, pc_r} < 17'(PROG_DEPTH);
  assign n_ok  = e_operand_r < 32'(DATA_DEPTH);
  assign d_ok  = rdata < 32'(DATA_DEPTH);          // first read gives M[n]
  assign la_ok = 32'(e_la_r) < 32'(DATA_DEPTH);

  // instruction and service op decode, all in the execute stage
  always_comb begin
    acc_nxt = acc_r;
    pc_nxt  = pc_r;
    hi_nxt  = hi_r;
    st      = ST_NORMAL;
    wr_req  = 1'b0;
    wr_a    = AW'(e_operand_r);
    wr_d    = acc_r;
    need2   = 1'b0;
    unique case (e_op_r)
      OP_EXEC: begin
        pc_nxt = pc_r + 16'd1;
        if (!pc_ok) begin
          st = ST_VIOLATION;
        end else begin
          unique case (e_opcode_r)
            OPC_CARGI: acc_nxt = e_operand_r;
            OPC_CARGM: begin
              if (n_ok) acc_nxt = rdata;
              else st = ST_VIOLATION;
            end
            OPC_CARGX: begin
              if (!n_ok) begin
                st = ST_VIOLATION;
              end else if (!e_phase_r) begin
                if (d_ok) need2 = 1'b1;
                else st = ST_VIOLATION;
              end else begin
                acc_nxt = rdata;                  // second read gives M[M[n]]
              end
            end
            OPC_ARMM: begin
              if (n_ok) begin
                wr_req = 1'b1;
                wr_a   = AW'(e_operand_r);
                if (wr_a > hi_r) hi_nxt = wr_a;
              end else begin
                st = ST_VIOLATION;
              end
            end
            OPC_ARMX: begin
              if (n_ok && d_ok) begin
                wr_req = 1'b1;
                wr_a   = AW'(rdata);
                if (wr_a > hi_r) hi_nxt = wr_a;
              end else begin
                st = ST_VIOLATION;
              end
            end
            OPC_SOMA: begin
              if (n_ok) acc_nxt = acc_r + rdata;
              else st = ST_VIOLATION;
            end
            OPC_NEG:   acc_nxt = 32'd0 - acc_r;
            OPC_DESVZ: begin
              if (acc_r == 32'd0) pc_nxt = e_operand_r[15:0];
            end
            OPC_PARA:  st = ST_STOP;
            OPC_LE:    st = ST_READ;
            OPC_GRAVA: st = ST_WRITE;
            default:   st = ST_ILLEGAL;
          endcase
        end
      end
      OP_LOAD: begin
        if (la_ok) begin
          wr_req = 1'b1;
          wr_a   = AW'(e_la_r);
          wr_d   = e_lv_r;
        end else begin
          st = ST_VIOLATION;
        end
      end
      OP_SETPC:  pc_nxt  = e_lv_r[15:0];
      OP_SETACC: acc_nxt = e_lv_r;
    endcase
  end

  // handshakes: the stage retires into the result register, or re-reads for CARGX
  assign slot_free = !o_vld_r || out_chan.ready;
  assign fire      = e_vld_r && !need2 && slot_free;
  assign step2     = e_vld_r && need2;
  assign in_chan.ready = !clr_r && (!e_vld_r || fire);
  assign in_fire   = in_chan.valid && in_chan.ready;

  // memory read on entry (M[n]) or for the dependent CARGX read (M[M[n]])
  assign rd_en   = in_fire || step2;
  assign rd_addr = step2 ? AW'(rdata) : AW'(in_chan.operand);

  // stores, data word loads and the clearing sweep share the write port
  assign wr_en   = clr_r || (fire && wr_req);
  assign wr_addr = clr_r ? clr_addr_r : wr_a;
  assign wr_data = clr_r ? 32'd0 : wr_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DATA_DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r   <= 1'b0;
      e_phase_r <= 1'b0;
    end else if (in_fire) begin
      e_vld_r   <= 1'b1;
      e_phase_r <= 1'b0;
    end else if (step2) begin
      e_phase_r <= 1'b1;
    end else if (fire) begin
      e_vld_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_op_r      <= in_chan.op;
      e_opcode_r  <= in_chan.opcode;
      e_operand_r <= in_chan.operand;
      e_la_r      <= in_chan.load_address;
      e_lv_r      <= in_chan.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pc_r  <= '0;
      hi_r  <= '0;
    end else if (fire) begin
      acc_r <= acc_nxt;
      pc_r  <= pc_nxt;
      hi_r  <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (fire) begin
      o_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_pc_r  <= pc_nxt;
      o_acc_r <= acc_nxt;
      o_st_r  <= st;
      o_hi_r  <= hi_nxt;
    end
  end

  assign out_chan.valid           = o_vld_r;
  assign out_chan.next_pc         = o_pc_r;
  assign out_chan.acc_value       = o_acc_r;
  assign out_chan.status          = o_st_r;
  assign out_chan.highest_address = 8'(o_hi_r);

endmodule

// ----- src/acc_cpu_chk.sv -----
// port-level checks of the accumulator cpu execute block, bound to the top level
module acc_cpu_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_highest_address
);

  import acc_cpu_pkg::*;

  logic [1:0] pend_r;
  logic [7:0] last_hi_r;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // beats accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      last_hi_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_fire) - 2'(out_fire);
      if (out_fire) last_hi_r <= out_highest_address;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_VIOLATION)
    else $error("result status out of range");

  a_hi_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_highest_address >= last_hi_r)
    else $error("highest address went down");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("more than two beats outstanding");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without an input beat");

endmodule

bind accumulator_cpu_execute_top acc_cpu_chk u_acc_cpu_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_highest_address (out_chan.highest_address)
);

// ----- test/tb_accumulator_cpu_execute_top.sv -----
// self-checking testbench for the accumulator cpu execute block with its own machine model
module tb_accumulator_cpu_execute_top;
  import acc_cpu_pkg::*;

  localparam int DATA_DEPTH      = 256;
  localparam int PROG_DEPTH      = 256;
  localparam int RANDOM_BEATS    = 1880;
  localparam int PHASE_SPAN      = 380;   // beats per idling phase
  localparam int PRESSURE_AT     = 1600;  // result count that starts the long hold-off
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int STALL_LIMIT     = 3000;  // covers the memory sweep and the hold-off
  localparam int PRINT_CAP       = 100;

  // illegal opcode range edges
  localparam logic [3:0] OPC_ILLEGAL_LO = 4'd11;
  localparam logic [3:0] OPC_ILLEGAL_HI = 4'd15;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  opcode;
    logic [31:0] operand;
    logic [7:0]  load_address;
    logic [31:0] load_value;
  } beat_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [31:0] acc;
    logic [2:0]  status;
    logic [7:0]  highest;
  } machine_state_t;

  logic clk;
  logic rst_n;

  acc_cpu_in_if  in_chan();
  acc_cpu_out_if out_chan();

  accumulator_cpu_execute_top #(
    .DATA_DEPTH(DATA_DEPTH),
    .PROG_DEPTH(PROG_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // machine model state
  logic [31:0] mach_acc;
  logic [15:0] mach_pc;
  logic [31:0] data_mem [DATA_DEPTH];
  logic [7:0]  mach_high;

  beat_t          pending_beats[$];
  machine_state_t expected_states[$];
  beat_t          cur_beat;

  int  beats_in;
  int  results_out;
  int  error_count;
  int  branches_taken;
  int  deepest_backlog;
  int  status_seen[8];
  int  idle_cycles;
  logic hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // address check as the machine sees it: unsigned, so negatives fall out too
  function automatic bit addr_fits(logic [31:0] a);
    return a < DATA_DEPTH;
  endfunction

  // advance the machine model by one beat and return what the block must report
  function automatic machine_state_t step_machine(beat_t b);
    machine_state_t r;
    logic [15:0] nxt;
    logic [31:0] ptr;
    r.status = ST_NORMAL;
    case (b.op)
      OP_EXEC: begin
        nxt = mach_pc + 16'd1;
        if (mach_pc >= PROG_DEPTH) begin
          // pc ran off the program, nothing executes but pc still steps
          r.status = ST_VIOLATION;
        end else begin
          case (b.opcode)
            OPC_CARGI: mach_acc = b.operand;
            OPC_CARGM: begin
              if (addr_fits(b.operand)) mach_acc = data_mem[b.operand];
              else r.status = ST_VIOLATION;
            end
            OPC_CARGX: begin
              if (addr_fits(b.operand) && addr_fits(data_mem[b.operand])) begin
                ptr = data_mem[b.operand];
                mach_acc = data_mem[ptr];
              end else r.status = ST_VIOLATION;
            end
            OPC_ARMM: begin
              if (addr_fits(b.operand)) begin
                data_mem[b.operand] = mach_acc;
                if (b.operand[7:0] > mach_high) mach_high = b.operand[7:0];
              end else r.status = ST_VIOLATION;
            end
            OPC_ARMX: begin
              if (addr_fits(b.operand) && addr_fits(data_mem[b.operand])) begin
                ptr = data_mem[b.operand];
                data_mem[ptr] = mach_acc;
                if (ptr[7:0] > mach_high) mach_high = ptr[7:0];
              end else r.status = ST_VIOLATION;
            end
            OPC_SOMA: begin
              if (addr_fits(b.operand)) mach_acc = mach_acc + data_mem[b.operand];
              else r.status = ST_VIOLATION;
            end
            OPC_NEG:   mach_acc = 32'd0 - mach_acc;
            OPC_DESVZ: begin
              if (mach_acc == 32'd0) begin
                nxt = b.operand[15:0];
                branches_taken++;
              end
            end
            OPC_PARA:  r.status = ST_STOP;
            OPC_LE:    r.status = ST_READ;
            OPC_GRAVA: r.status = ST_WRITE;
            default:   r.status = ST_ILLEGAL;
          endcase
        end
        mach_pc = nxt;
      end
      OP_LOAD: begin
        if (b.load_address < DATA_DEPTH) data_mem[b.load_address] = b.load_value;
        else r.status = ST_VIOLATION;
      end
      OP_SETPC: mach_pc = b.load_value[15:0];
      default:  mach_acc = b.load_value;
    endcase
    r.next_pc = mach_pc;
    r.acc     = mach_acc;
    r.highest = mach_high;
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic add_beat(logic [1:0] op, logic [3:0] opc, logic [31:0] n,
                          logic [7:0] la, logic [31:0] lv);
    beat_t b;
    b.op           = op;
    b.opcode       = opc;
    b.operand      = n;
    b.load_address = la;
    b.load_value   = lv;
    pending_beats.push_back(b);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("mismatch on result %0d, %0s: got 0x%08h want 0x%08h",
               results_out, field, got, want);
    error_count++;
  endtask

  // idling per phase: none, sender 54, receiver 54, both 24, then around again
  function automatic bit gap_roll(int count, bit receiver_side);
    int mode;
    mode = (count / PHASE_SPAN) % 4;
    if (mode == 3) return $urandom_range(0, 99) < 24;
    if (receiver_side ? (mode == 2) : (mode == 1)) return $urandom_range(0, 99) < 54;
    return 1'b0;
  endfunction

  // sender: offer the next queued beat when the channel is free and the idling roll allows
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        // beat taken at this edge, predict its result now so order follows acceptance
        expected_states.push_back(step_machine(cur_beat));
        beats_in++;
        if (expected_states.size() > deepest_backlog)
          deepest_backlog = expected_states.size();
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_beats.size() != 0 && !gap_roll(beats_in, 1'b0)) begin
          cur_beat = pending_beats.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.op           <= cur_beat.op;
          in_chan.opcode       <= cur_beat.opcode;
          in_chan.operand      <= cur_beat.operand;
          in_chan.load_address <= cur_beat.load_address;
          in_chan.load_value   <= cur_beat.load_value;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result beat against the oldest prediction
  always @(posedge clk) begin
    machine_state_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_states.size() == 0) begin
          report_mismatch("result with nothing pending, pc", 32'(out_chan.next_pc), 32'd0);
        end else begin
          want = expected_states.pop_front();
          if (out_chan.next_pc !== want.next_pc)
            report_mismatch("next_pc", 32'(out_chan.next_pc), 32'(want.next_pc));
          if (out_chan.acc_value !== want.acc)
            report_mismatch("acc_value", out_chan.acc_value, want.acc);
          if (out_chan.status !== want.status)
            report_mismatch("status", 32'(out_chan.status), 32'(want.status));
          if (out_chan.highest_address !== want.highest)
            report_mismatch("highest_address", 32'(out_chan.highest_address),
                            32'(want.highest));
        end
        results_out++;
      end
      out_chan.ready <= !hold_off && !gap_roll(results_out, 1'b1);
    end
  end

  // long receiver hold-off while the sender keeps pushing, so the block backs up
  initial begin
    hold_off = 1'b0;
    wait (results_out >= PRESSURE_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("accumulator_cpu_execute_top verification failed");
      $finish;
    end
  end

  initial begin
    beat_t b;
    int    roll;
    int    span;

    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.op           = OP_EXEC;
    in_chan.opcode       = OPC_CARGI;
    in_chan.operand      = '0;
    in_chan.load_address = '0;
    in_chan.load_value   = '0;
    out_chan.ready       = 1'b0;
    beats_in        = 0;
    results_out     = 0;
    error_count     = 0;
    branches_taken  = 0;
    deepest_backlog = 0;
    idle_cycles     = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    mach_acc  = '0;
    mach_pc   = '0;
    mach_high = '0;
    foreach (data_mem[i]) data_mem[i] = '0;

    // directed: wrap at both ends of the accumulator, the edges of the data memory
    add_beat(OP_SETACC, 4'($urandom), $urandom, 8'($urandom), 32'h7fff_ffff);
    add_beat(OP_LOAD, 4'($urandom), $urandom, 8'd255, 32'd1);
    add_beat(OP_LOAD, 4'($urandom), $urandom, 8'd0, 32'h8000_0000);
    add_beat(OP_EXEC, OPC_SOMA, 32'd255, 8'($urandom), $urandom);  // overflows to most negative
    add_beat(OP_EXEC, OPC_NEG, $urandom, 8'($urandom), $urandom);  // most negative negates to itself
    add_beat(OP_EXEC, OPC_ARMM, 32'd0, 8'($urandom), $urandom);    // store at 0 keeps highest at 0
    add_beat(OP_EXEC, OPC_CARGI, 32'd0, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_DESVZ, 32'hffff_0010, 8'($urandom), $urandom); // taken, low half kept
    add_beat(OP_EXEC, OPC_CARGM, 32'hffff_ffff, 8'($urandom), $urandom); // negative address
    add_beat(OP_EXEC, OPC_SOMA, 32'd256, 8'($urandom), $urandom);        // one past the end
    // indirect forms, good pointer and pointer out of range
    add_beat(OP_LOAD, 4'($urandom), $urandom, 8'd5, 32'd7);
    add_beat(OP_LOAD, 4'($urandom), $urandom, 8'd7, 32'h1234_5678);
    add_beat(OP_EXEC, OPC_CARGX, 32'd5, 8'($urandom), $urandom);
    add_beat(OP_LOAD, 4'($urandom), $urandom, 8'd6, 32'd300);
    add_beat(OP_EXEC, OPC_CARGX, 32'd6, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_ARMX, 32'd6, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_ARMX, 32'd5, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_DESVZ, 32'd3, 8'($urandom), $urandom);         // acc nonzero, falls through
    add_beat(OP_EXEC, OPC_PARA, $urandom, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_LE, $urandom, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_GRAVA, $urandom, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_ILLEGAL_LO, $urandom, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_ILLEGAL_HI, $urandom, 8'($urandom), $urandom);
    // pc at the top of 16 bits, then at the last program word and past it
    add_beat(OP_SETPC, 4'($urandom), $urandom, 8'($urandom), 32'habcd_ffff);
    add_beat(OP_EXEC, OPC_CARGI, 32'd5, 8'($urandom), $urandom);         // violation, pc wraps to 0
    add_beat(OP_SETPC, 4'($urandom), $urandom, 8'($urandom), 32'(PROG_DEPTH - 1));
    add_beat(OP_EXEC, OPC_CARGI, 32'hffff_ffff, 8'($urandom), $urandom);
    add_beat(OP_EXEC, OPC_NEG, $urandom, 8'($urandom), $urandom);        // pc past program

    // random programs: mostly valid addresses, small data words so pointers resolve,
    // the store window widens slowly so the highest address climbs over the run
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      span = (16 + i / 6 > DATA_DEPTH - 1) ? DATA_DEPTH - 1 : 16 + i / 6;
      roll = $urandom_range(0, 99);
      b.op           = OP_EXEC;
      b.opcode       = 4'($urandom);
      b.operand      = $urandom;
      b.load_address = 8'($urandom);
      b.load_value   = $urandom;
      if (roll < 12) begin
        b.op = OP_LOAD;
        if ($urandom_range(0, 1) == 0) b.load_address = 8'($urandom_range(0, 31));
        roll = $urandom_range(0, 9);
        if (roll < 5) b.load_value = $urandom_range(0, 40);
        else if (roll < 7) b.load_value = $urandom_range(240, 300);
      end else if (roll < 16) begin
        b.op = OP_SETPC;
        if ($urandom_range(0, 9) != 0)
          b.load_value[15:0] = 16'($urandom_range(0, PROG_DEPTH - 1));
      end else if (roll < 20) begin
        b.op = OP_SETACC;
        if ($urandom_range(0, 1) == 0) b.load_value = '0;
      end else begin
        if ($urandom_range(0, 19) == 0)
          b.opcode = 4'($urandom_range(OPC_ILLEGAL_LO, OPC_ILLEGAL_HI));
        else b.opcode = 4'($urandom_range(OPC_CARGI, OPC_GRAVA));
        case (b.opcode)
          OPC_CARGI: begin
            if ($urandom_range(0, 2) != 0) b.operand = $urandom_range(0, 15);
          end
          OPC_DESVZ: begin
            if ($urandom_range(0, 4) != 0)
              b.operand[15:0] = 16'($urandom_range(0, PROG_DEPTH - 1));
          end
          OPC_CARGM, OPC_CARGX, OPC_ARMM, OPC_ARMX, OPC_SOMA: begin
            // one in ten keeps the wild operand, mostly out of range
            if ($urandom_range(0, 9) != 0) b.operand = $urandom_range(0, span);
          end
          default: ;
        endcase
      end
      pending_beats.push_back(b);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_chan.valid || expected_states.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats, %0d results; status normal %0d stop %0d read %0d write %0d",
             beats_in, results_out, status_seen[ST_NORMAL], status_seen[ST_STOP],
             status_seen[ST_READ], status_seen[ST_WRITE]);
    $display("illegal %0d violation %0d, branches taken %0d, top store %0d, backlog %0d",
             status_seen[ST_ILLEGAL], status_seen[ST_VIOLATION], branches_taken, mach_high,
             deepest_backlog);
    if (error_count == 0 && expected_states.size() == 0) begin
      $display("accumulator_cpu_execute_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", error_count, expected_states.size());
      $display("accumulator_cpu_execute_top verification failed");
    end
    $finish;
  end

endmodule
